### hdl/i2cmbw_pkg.sv
// Shared types and constants for the I2C single byte write master.
// Used by the core, the output register and the top level.
package i2cmbw_pkg;

    localparam int DelayWidth = 16;
    localparam logic [DelayWidth-1:0] DelayReset = 16'd10;
    localparam logic [3:0] BitsPerByte = 4'd8;

    typedef logic [DelayWidth-1:0] delay_t;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_START_A   = 12'b0000_0000_0010,
        PH_START_B   = 12'b0000_0000_0100,
        PH_BIT_LOW   = 12'b0000_0000_1000,
        PH_BIT_SETUP = 12'b0000_0001_0000,
        PH_BIT_HIGH  = 12'b0000_0010_0000,
        PH_ACK_LOW   = 12'b0000_0100_0000,
        PH_ACK_HIGH  = 12'b0000_1000_0000,
        PH_GAP       = 12'b0001_0000_0000,
        PH_STOP_A    = 12'b0010_0000_0000,
        PH_STOP_B    = 12'b0100_0000_0000,
        PH_STOP_C    = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic rel;
        logic busy;
        logic done;
        logic ack;
    } res_t;

endpackage

### hdl/i2c_master_byte_write_unit.sv
// I2C master, single byte write: one tick per input transfer, one result each.
// A result is registered and appears in the cycle after its input transfer is accepted.
// Throughput: one transfer per cycle while in_stall is low, set by the single pass
// from the state registers through the sequencer logic into the result register.
// Reset: asynchronous, active low; idle bus, empty result register, half_delay 10.
module i2c_master_byte_write_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  i2cmbw_pkg::delay_t     cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   start_request,
    input  logic [6:0]             target_address,
    input  logic [7:0]             write_data,
    input  logic                   sda_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   scl_level,
    output logic                   sda_level,
    output logic                   sda_released,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   acked
);
    import i2cmbw_pkg::*;

    delay_t half_delay_reg;
    logic   accept;
    logic   blocked;
    res_t   core_res;
    res_t   held_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_delay_reg <= DelayReset;
        end
        else if (cfg_we)
        begin
            half_delay_reg <= cfg_wdata;
        end
    end

    assign in_stall = blocked;
    assign accept   = in_valid & ~blocked;

    i2cmbw_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .half_delay     (half_delay_reg),
        .start_request  (start_request),
        .target_address (target_address),
        .write_data     (write_data),
        .sda_in         (sda_in),
        .res            (core_res)
    );

    i2cmbw_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res_in       (core_res),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .full_blocked (blocked),
        .res_out      (held_res)
    );

    assign scl_level    = held_res.scl;
    assign sda_level    = held_res.sda;
    assign sda_released = held_res.rel;
    assign busy_res     = held_res.busy;
    assign done_res     = held_res.done;
    assign acked        = held_res.ack;

endmodule

### hdl/i2cmbw_core.sv
// Bus sequencer for the I2C single byte write master: state registers and
// the per-tick next-state and bus-level logic. Depends on i2cmbw_pkg.
module i2cmbw_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  i2cmbw_pkg::delay_t     half_delay,
    input  logic                   start_request,
    input  logic [6:0]             target_address,
    input  logic [7:0]             write_data,
    input  logic                   sda_in,
    output i2cmbw_pkg::res_t       res
);
    import i2cmbw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  saved_reg, saved_next;
    delay_t      wait_reg, wait_next;
    logic        on_data_reg, on_data_next;
    logic        nack_reg, nack_next;
    logic        sda_hold_reg, sda_hold_next;

    always_comb
    begin
        phase_t      ph;
        logic [3:0]  bidx;
        logic [3:0]  bidx_inc;
        logic [7:0]  sh;
        logic [7:0]  saved;
        delay_t      wcnt;
        delay_t      limit;
        logic        on_data;
        logic        nack;
        logic        hold;
        logic        last;
        logic        cur_bit;

        ph      = phase_reg;
        bidx    = bit_index_reg;
        sh      = shift_reg;
        saved   = saved_reg;
        wcnt    = wait_reg;
        on_data = on_data_reg;
        nack    = nack_reg;
        hold    = sda_hold_reg;

        // Codes that are not a single hot bit behave as idle.
        if (!$onehot(phase_reg))
        begin
            ph = PH_IDLE;
        end

        // A request while idle makes this tick the first tick of the start.
        if (ph == PH_IDLE && start_request)
        begin
            sh      = {target_address, 1'b0};
            saved   = write_data;
            bidx    = '0;
            on_data = 1'b0;
            nack    = 1'b0;
            wcnt    = '0;
            hold    = 1'b1;
            ph      = PH_START_A;
        end

        res      = '{scl: 1'b1, sda: 1'b1, rel: 1'b0, busy: 1'b0, done: 1'b0, ack: 1'b0};
        cur_bit  = sh[7];
        limit    = (half_delay == '0) ? delay_t'(1) : half_delay;
        last     = ({1'b0, wcnt} + 17'd1) >= {1'b0, limit};
        bidx_inc = bidx + 4'd1;

        if (ph != PH_IDLE)
        begin
            res.busy = 1'b1;
            case (ph)
                PH_START_A:   begin res.scl = 1'b1; res.sda = 1'b1; end
                PH_START_B:   begin res.scl = 1'b1; res.sda = 1'b0; end
                PH_BIT_LOW:   begin res.scl = 1'b0; res.sda = hold; end
                PH_BIT_SETUP: begin res.scl = 1'b0; res.sda = cur_bit; end
                PH_BIT_HIGH:  begin res.scl = 1'b1; res.sda = cur_bit; end
                PH_ACK_LOW:   begin res.scl = 1'b0; res.sda = 1'b1; res.rel = 1'b1; end
                PH_ACK_HIGH:  begin res.scl = 1'b1; res.sda = 1'b1; res.rel = 1'b1; end
                PH_GAP:       begin res.scl = 1'b0; res.sda = 1'b1; end
                PH_STOP_A:    begin res.scl = 1'b0; res.sda = 1'b0; end
                PH_STOP_B:    begin res.scl = 1'b1; res.sda = 1'b0; end
                default:      begin res.scl = 1'b1; res.sda = 1'b1; end
            endcase
            hold = res.sda;

            wcnt = wcnt + delay_t'(1);
            if (last)
            begin
                wcnt = '0;
                case (ph)
                    PH_START_A:   ph = PH_START_B;
                    PH_START_B:   ph = PH_BIT_LOW;
                    PH_BIT_LOW:   ph = PH_BIT_SETUP;
                    PH_BIT_SETUP: ph = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        sh = {sh[6:0], 1'b0};
                        if (bidx_inc >= BitsPerByte)
                        begin
                            bidx = '0;
                            ph   = PH_ACK_LOW;
                        end
                        else
                        begin
                            bidx = bidx_inc;
                            ph   = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_LOW:   ph = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        // A high level in the acknowledge slot is a NACK.
                        nack = nack | sda_in;
                        if (!on_data && !nack)
                        begin
                            on_data = 1'b1;
                            sh      = saved;
                            ph      = PH_GAP;
                        end
                        else
                        begin
                            ph = PH_STOP_A;
                        end
                    end
                    PH_GAP:       ph = PH_BIT_LOW;
                    PH_STOP_A:    ph = PH_STOP_B;
                    PH_STOP_B:    ph = PH_STOP_C;
                    default:
                    begin
                        res.done = 1'b1;
                        res.ack  = !nack;
                        ph       = PH_IDLE;
                    end
                endcase
            end
        end

        phase_next     = ph;
        bit_index_next = bidx;
        shift_next     = sh;
        saved_next     = saved;
        wait_next      = wcnt;
        on_data_next   = on_data;
        nack_next      = nack;
        sda_hold_next  = hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            saved_reg     <= '0;
            wait_reg      <= '0;
            on_data_reg   <= 1'b0;
            nack_reg      <= 1'b0;
            sda_hold_reg  <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            saved_reg     <= saved_next;
            wait_reg      <= wait_next;
            on_data_reg   <= on_data_next;
            nack_reg      <= nack_next;
            sda_hold_reg  <= sda_hold_next;
        end
    end

endmodule

### hdl/i2cmbw_out_reg.sv
// Result register for the I2C single byte write master. Holds one result
// until it is taken and frees itself in the same cycle. Depends on i2cmbw_pkg.
module i2cmbw_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  i2cmbw_pkg::res_t   res_in,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               full_blocked,
    output i2cmbw_pkg::res_t   res_out
);
    import i2cmbw_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    // A new result may enter when the register is empty or is drained now.
    assign full_blocked = valid_reg & out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

### hdl/i2cmbw_checker.sv
// Port-level checks for the I2C single byte write master, and the bind
// that attaches them to i2c_master_byte_write_unit.
module i2cmbw_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic scl_level,
    input logic sda_level,
    input logic sda_released,
    input logic busy_res,
    input logic done_res,
    input logic acked
);

    // The acknowledge flag only comes with the end of a transfer.
    a_ack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && acked |-> done_res)
        else $error("acked without done_res");

    // The last tick of a transfer still counts as busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done_res without busy_res");

    // A released data line shows high and only inside a transfer.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sda_released |-> sda_level && busy_res)
        else $error("sda_released outside a transfer or with sda low");

    // An idle bus leaves both lines high.
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> scl_level && sda_level && !sda_released)
        else $error("idle bus not high");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scl_level)
            && $stable(sda_level) && $stable(busy_res) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_write_unit i2cmbw_checker u_i2cmbw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .sda_released (sda_released),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .acked        (acked)
);
